// ----- rtl/ilsk_pkg.sv -----
package ilsk_pkg;

  localparam int MAX_WORDS_DEF = 8;
  localparam int WORD_HOLD     = 5;
  localparam int LEAD_DEPTH    = 8;
  localparam int NUM_LEADS     = 21;

  typedef logic [7:0] char_t;
  typedef logic [3:0] max_words_t;

  // Lead-in words, left aligned: the first character sits in the top byte.
  localparam logic [39:0] LEAD_TEXT [NUM_LEADS] = '{
    {"it", 24'h0}, {"its", 16'h0}, {"that", 8'h0}, {"this", 8'h0}, "these", "those",
    {"is", 24'h0}, {"are", 16'h0}, {"a", 32'h0}, {"an", 24'h0}, {"the", 16'h0},
    {"some", 8'h0}, {"one", 16'h0}, {"just", 8'h0}, {"my", 24'h0}, {"your", 8'h0},
    "looks", {"like", 8'h0}, "seems", {"to", 24'h0}, {"be", 24'h0}
  };

  localparam logic [2:0] LEAD_LEN [NUM_LEADS] = '{
    3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd2, 3'd3, 3'd1, 3'd2, 3'd3,
    3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd5, 3'd4, 3'd5, 3'd2, 3'd2
  };

  typedef enum logic [1:0] {
    CLS_DROP,
    CLS_BRK,
    CLS_CHR
  } cls_t;

  typedef enum logic [1:0] {
    CTX_CHAR,
    CTX_NEW,
    CTX_BRK,
    CTX_LAST
  } ctx_t;

  typedef enum logic [2:0] {
    EM_SEP,
    EM_HELD,
    EM_CUR,
    EM_LEAD,
    EM_TERM
  } emit_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ENDW,
    ST_FLUSH,
    ST_SEP,
    ST_HELD,
    ST_CUR,
    ST_ENDFIN,
    ST_LASTCHK,
    ST_LEADS,
    ST_LEADSEP,
    ST_LEADCH,
    ST_TERM
  } state_t;

  typedef struct packed {
    logic      load_in;
    logic      store_char;
    logic      lead_clr;
    logic      start_emit;
    logic      stop_emit;
    logic      store_lead;
    logic      endw_clear;
    logic      set_nonempty;
    logic      held_inc;
    logic      lead_pos_inc;
    logic      lead_next;
    logic      clear_state;
    logic      emit;
    emit_sel_t emit_sel;
    logic      run_end;
  } dp_cmd_t;

  typedef struct packed {
    cls_t cls;
    logic last_in;
    logic lead;
    logic wlen_full;
    logic wlen_nz;
    logic match_hit;
    logic emitting;
    logic room;
    logic held_final;
    logic lead_more;
    logic lead_char_final;
    logic out_free;
  } dp_status_t;

  function automatic logic [2:0] lead_len(input logic [4:0] idx);
    logic [4:0] k;
    k = (idx < 5'(NUM_LEADS)) ? idx : 5'd0;
    return LEAD_LEN[k];
  endfunction

  function automatic char_t lead_char(input logic [4:0] idx, input logic [2:0] pos);
    logic [4:0]  k;
    logic [39:0] s;
    k = (idx < 5'(NUM_LEADS)) ? idx : 5'd0;
    s = LEAD_TEXT[k] << {pos, 3'b000};
    return s[39:32];
  endfunction

endpackage

// ----- rtl/ilsk_in_if.sv -----
interface ilsk_in_if;
  logic              valid;
  logic              ready;
  ilsk_pkg::char_t   char_in;
  logic              last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

// ----- rtl/ilsk_out_if.sv -----
interface ilsk_out_if;
  logic              valid;
  logic              ready;
  ilsk_pkg::char_t   char_out;
  logic              has_char;
  logic              name_done;
  logic              last_of_run;

  modport source (output valid, output char_out, output has_char, output name_done,
                  output last_of_run, input ready);
  modport sink   (input valid, input char_out, input has_char, input name_done,
                  input last_of_run, output ready);
endinterface

// ----- rtl/item_slug_leadin_skipper_top.sv -----
// Turns a description, one byte per request with a flag on the final byte, into an
// identifier-style item name: letters are folded to lower case, digits kept, blanks, tabs,
// hyphens and underscores split words, and other bytes are dropped. Leading lead-in words
// ("the", "this", "looks", ...) are skipped, the following words are sent one character
// per result with an underscore between them, up to min(max_words, MAX_WORDS) words; if
// every word is a lead-in, the stored lead-ins are sent. Each description ends with a
// terminating result that has name_done set, and last_of_run marks the final result of
// each request. One request is worked on at a time by a sequencer, which passes through a
// separator slot before each word, even at the start of the name where no underscore is
// sent. A word break ends the word and sends a held word if any, and the final byte also
// replays the stored lead-ins if the name is still in its lead phase. A result waiting on
// a stalled output holds the sequencer; the output register lets the next request be taken
// while the last result of the previous one is still waiting.
module item_slug_leadin_skipper_top #(
  parameter int MAX_WORDS = ilsk_pkg::MAX_WORDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  ilsk_pkg::max_words_t cfg_write_data,
  ilsk_in_if.sink              in_ch,
  ilsk_out_if.source           out_ch
);
  import ilsk_pkg::*;

  dp_cmd_t    ctl_cmd;
  dp_status_t dp_stat;

  ilsk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (dp_stat),
    .cmd      (ctl_cmd)
  );

  ilsk_datapath #(
    .MAX_WORDS (MAX_WORDS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .char_in        (in_ch.char_in),
    .last_char      (in_ch.last_char),
    .cmd            (ctl_cmd),
    .stat           (dp_stat),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .char_out       (out_ch.char_out),
    .has_char       (out_ch.has_char),
    .name_done      (out_ch.name_done),
    .last_of_run    (out_ch.last_of_run)
  );

  // The sequencer never loads a result while the output register is still occupied.
  assert property (@(posedge clk) disable iff (rst) ctl_cmd.emit |-> dp_stat.out_free)
    else $error("result loaded over an untaken result");

  // One request at a time: a taken request is never followed by another in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while the previous one is in work");

  // The terminating result always closes the run and carries no character.
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.name_done) |-> (out_ch.last_of_run && !out_ch.has_char))
    else $error("terminator without last_of_run or with a character");

  // Lead-in words are only replayed while the block is still in its lead phase.
  assert property (@(posedge clk) disable iff (rst)
    (ctl_cmd.emit && (ctl_cmd.emit_sel == EM_LEAD)) |-> dp_stat.lead)
    else $error("lead-in replay after the lead phase ended");

endmodule

// ----- rtl/ilsk_ctrl.sv -----
module ilsk_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ilsk_pkg::dp_status_t stat,
  output ilsk_pkg::dp_cmd_t    cmd
);
  import ilsk_pkg::*;

  state_t state, state_next;
  ctx_t   ctx, ctx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ctx   <= CTX_CHAR;
    end else begin
      state <= state_next;
      ctx   <= ctx_next;
    end
  end

  always_comb begin
    state_next = state;
    ctx_next   = ctx;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat.cls)
          CLS_BRK: begin
            ctx_next   = CTX_BRK;
            state_next = ST_ENDW;
          end
          CLS_CHR: begin
            if (stat.lead) begin
              if (!stat.wlen_full) begin
                cmd.store_char = 1'b1;
                state_next     = ST_LASTCHK;
              end else begin
                // A sixth character cannot belong to a lead-in.
                ctx_next   = CTX_CHAR;
                state_next = ST_FLUSH;
              end
            end else if (stat.emitting) begin
              state_next = ST_CUR;
            end else if (stat.room) begin
              cmd.start_emit = 1'b1;
              ctx_next       = CTX_NEW;
              state_next     = ST_SEP;
            end else begin
              state_next = ST_LASTCHK;
            end
          end
          default: state_next = ST_LASTCHK;
        endcase
      end
      ST_ENDW: begin
        if (stat.lead && stat.wlen_nz) begin
          if (stat.match_hit) begin
            cmd.store_lead = 1'b1;
            state_next     = ST_ENDFIN;
          end else begin
            state_next = ST_FLUSH;
          end
        end else begin
          state_next = ST_ENDFIN;
        end
      end
      ST_FLUSH: begin
        cmd.lead_clr = 1'b1;
        if (stat.room) begin
          cmd.start_emit = 1'b1;
          state_next     = ST_SEP;
        end else begin
          cmd.stop_emit = 1'b1;
          state_next    = (ctx == CTX_CHAR) ? ST_LASTCHK : ST_ENDFIN;
        end
      end
      ST_SEP: begin
        if (stat.out_free) begin
          cmd.emit         = 1'b1;
          cmd.emit_sel     = EM_SEP;
          cmd.set_nonempty = 1'b1;
          state_next       = (ctx == CTX_NEW) ? ST_CUR : ST_HELD;
        end
      end
      ST_HELD: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_HELD;
          cmd.held_inc = 1'b1;
          cmd.run_end  = stat.held_final && (ctx == CTX_BRK) && !stat.last_in;
          if (stat.held_final) begin
            state_next = (ctx == CTX_CHAR) ? ST_CUR : ST_ENDFIN;
          end
        end
      end
      ST_CUR: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_CUR;
          cmd.run_end  = !stat.last_in;
          state_next   = ST_LASTCHK;
        end
      end
      ST_ENDFIN: begin
        cmd.endw_clear = 1'b1;
        state_next     = (ctx == CTX_LAST) ? ST_LEADS : ST_LASTCHK;
      end
      ST_LASTCHK: begin
        if (stat.last_in) begin
          ctx_next   = CTX_LAST;
          state_next = ST_ENDW;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_LEADS: begin
        state_next = (stat.lead && stat.lead_more) ? ST_LEADSEP : ST_TERM;
      end
      ST_LEADSEP: begin
        if (stat.out_free) begin
          cmd.emit         = 1'b1;
          cmd.emit_sel     = EM_SEP;
          cmd.set_nonempty = 1'b1;
          state_next       = ST_LEADCH;
        end
      end
      ST_LEADCH: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_LEAD;
          if (stat.lead_char_final) begin
            cmd.lead_next = 1'b1;
            state_next    = ST_LEADS;
          end else begin
            cmd.lead_pos_inc = 1'b1;
          end
        end
      end
      ST_TERM: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_sel    = EM_TERM;
          cmd.run_end     = 1'b1;
          cmd.clear_state = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/ilsk_datapath.sv -----
module ilsk_datapath #(
  parameter int MAX_WORDS = ilsk_pkg::MAX_WORDS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_en,
  input  ilsk_pkg::max_words_t   cfg_write_data,
  input  ilsk_pkg::char_t        char_in,
  input  logic                   last_char,
  input  ilsk_pkg::dp_cmd_t      cmd,
  output ilsk_pkg::dp_status_t   stat,
  input  logic                   out_ready,
  output logic                   out_valid,
  output ilsk_pkg::char_t        char_out,
  output logic                   has_char,
  output logic                   name_done,
  output logic                   last_of_run
);
  import ilsk_pkg::*;

  localparam int WW = $clog2(MAX_WORDS + 1);
  localparam char_t CH_UNDERSCORE = 8'h5F;

  // Folds a raw byte into a class and a lower case character.
  function automatic cls_t fold_cls(input char_t b);
    cls_t r;
    r = CLS_DROP;
    if ((b inside {[8'h41:8'h5A]}) || (b inside {[8'h61:8'h7A]}) ||
        (b inside {[8'h30:8'h39]})) begin
      r = CLS_CHR;
    end else if (b inside {8'h20, 8'h09, 8'h2D, 8'h5F}) begin
      r = CLS_BRK;
    end
    return r;
  endfunction

  function automatic char_t fold_char(input char_t b);
    return (b inside {[8'h41:8'h5A]}) ? (b | 8'h20) : b;
  endfunction

  max_words_t      max_words;
  cls_t            cur_cls;
  char_t           cur_char;
  logic            last_in;
  logic            lead;
  char_t           word_chars [WORD_HOLD];
  logic [2:0]      wlen;
  logic [4:0]      lead_store [LEAD_DEPTH];
  logic [3:0]      lead_cnt;
  logic [WW-1:0]   words;
  logic            nonempty;
  logic            emitting;
  logic [2:0]      held_idx;
  logic [3:0]      lead_i;
  logic [2:0]      lead_pos;

  logic [WW-1:0]   lim;
  logic            match_hit;
  logic [4:0]      match_idx;
  logic [4:0]      lead_cur;
  logic            out_free;
  logic            emit_now;
  char_t           emit_char;

  assign lim = (32'(max_words) > MAX_WORDS) ? WW'(MAX_WORDS) : WW'(max_words);
  assign lead_cur = lead_store[lead_i[2:0]];
  assign out_free = !out_valid || out_ready;
  // A separator is only placed between words.
  assign emit_now = cmd.emit && ((cmd.emit_sel != EM_SEP) || nonempty);

  always_comb begin
    logic eq;
    match_hit = 1'b0;
    match_idx = '0;
    for (int i = NUM_LEADS - 1; i >= 0; i--) begin
      eq = (LEAD_LEN[i] == wlen);
      for (int j = 0; j < WORD_HOLD; j++) begin
        if ((3'(j) < wlen) && (word_chars[j] != lead_char(5'(i), 3'(j)))) begin
          eq = 1'b0;
        end
      end
      if (eq) begin
        match_hit = 1'b1;
        match_idx = 5'(i);
      end
    end
  end

  always_comb begin
    case (cmd.emit_sel)
      EM_SEP:  emit_char = CH_UNDERSCORE;
      EM_HELD: emit_char = word_chars[held_idx];
      EM_CUR:  emit_char = cur_char;
      EM_LEAD: emit_char = lead_char(lead_cur, lead_pos);
      default: emit_char = '0;
    endcase
  end

  always_comb begin
    stat.cls             = cur_cls;
    stat.last_in         = last_in;
    stat.lead            = lead;
    stat.wlen_full       = (wlen == 3'(WORD_HOLD));
    stat.wlen_nz         = (wlen != 3'd0);
    stat.match_hit       = match_hit;
    stat.emitting        = emitting;
    stat.room            = (words < lim);
    stat.held_final      = (held_idx == wlen - 3'd1);
    stat.lead_more       = (lead_i < lead_cnt) && (32'(lead_i) < 32'(lim));
    stat.lead_char_final = (lead_pos == lead_len(lead_cur) - 3'd1);
    stat.out_free        = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_words <= 4'd3;
      lead      <= 1'b1;
      wlen      <= '0;
      lead_cnt  <= '0;
      words     <= '0;
      nonempty  <= 1'b0;
      emitting  <= 1'b0;
      held_idx  <= '0;
      lead_i    <= '0;
      lead_pos  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_en) max_words <= cfg_write_data;
      if (cmd.load_in) begin
        held_idx <= '0;
        lead_i   <= '0;
        lead_pos <= '0;
      end
      if (cmd.store_char) wlen <= wlen + 3'd1;
      if (cmd.lead_clr) lead <= 1'b0;
      if (cmd.start_emit) begin
        words    <= words + WW'(1);
        emitting <= 1'b1;
      end
      if (cmd.stop_emit) emitting <= 1'b0;
      if (cmd.store_lead && (lead_cnt < 4'(LEAD_DEPTH))) lead_cnt <= lead_cnt + 4'd1;
      if (cmd.endw_clear) begin
        emitting <= 1'b0;
        wlen     <= '0;
      end
      if (cmd.set_nonempty) nonempty <= 1'b1;
      if (cmd.held_inc) held_idx <= held_idx + 3'd1;
      if (cmd.lead_pos_inc) lead_pos <= lead_pos + 3'd1;
      if (cmd.lead_next) begin
        lead_i   <= lead_i + 4'd1;
        lead_pos <= '0;
      end
      if (cmd.clear_state) begin
        lead     <= 1'b1;
        wlen     <= '0;
        lead_cnt <= '0;
        words    <= '0;
        nonempty <= 1'b0;
        emitting <= 1'b0;
      end
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_cls  <= fold_cls(char_in);
      cur_char <= fold_char(char_in);
      last_in  <= last_char;
    end
    if (cmd.store_char) word_chars[wlen] <= cur_char;
    if (cmd.store_lead && (lead_cnt < 4'(LEAD_DEPTH))) lead_store[lead_cnt[2:0]] <= match_idx;
    if (emit_now) begin
      char_out    <= emit_char;
      has_char    <= (cmd.emit_sel != EM_TERM);
      name_done   <= (cmd.emit_sel == EM_TERM);
      last_of_run <= cmd.run_end;
    end
  end

endmodule
